### design/cws_pkg.sv
// Shared types and constants for the combo weight solver.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package cws_pkg;

  localparam int MAG_W = 15;
  localparam int SUM_W = 20;
  localparam int QUO_W = 15;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // solve modes
  localparam logic [2:0] MODE_MIN      = 3'd0;
  localparam logic [2:0] MODE_PRODUCT  = 3'd1;
  localparam logic [2:0] MODE_MIN_MAX  = 3'd2;
  localparam logic [2:0] MODE_EXT_HARM = 3'd3;
  localparam logic [2:0] MODE_ALL_HARM = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SOLVE_MODE     = 2'd0;
  localparam logic [1:0] CFG_MAX_VALUE      = 2'd1;
  localparam logic [1:0] CFG_ZERO_TOLERANCE = 2'd2;

  localparam logic [2:0]       SOLVE_MODE_RST     = MODE_MIN;
  localparam logic [MAG_W-1:0] MAX_VALUE_RST      = 15'd16384;
  localparam logic [7:0]       ZERO_TOLERANCE_RST = 8'd1;

  // summary of one finished run, handed from front to back
  typedef struct packed {
    logic             mismatch;
    logic [MAG_W-1:0] run_min;
    logic [MAG_W-1:0] run_max;
    logic [MAG_W-1:0] run_product;
    logic [SUM_W-1:0] run_sum;
  } cws_run_t;

endpackage

### design/combo_weight_solver_unit.sv
// Top level of the combo weight solver: configuration registers, front end,
// run queue and back end. Depends on cws_pkg, cws_front, cws_queue, cws_back.
`timescale 1ns / 1ps
//
// Usage
//   in_*  : one (slider, target) pair per transfer; in_last_pair closes a run.
//           Pairs are taken one per cycle while the run queue has room.
//   out_* : one result per run (signs_match, weight), held until transferred.
//   cfg_* : register writes, always ready; write only while the block is idle.
// After a run's last pair the back end pops its summary and multiplies; modes
//   min, product and min*max and the zero or saturated cases give the result
//   directly, the harmonic modes use the divider at one quotient bit per cycle.
// Throughput: one pair per cycle while the queue has room; the back end solves
//   runs one at a time, while a two-entry queue lets the front keep taking pairs.
// Reset clears the run state, empties the queue and loads the register
//   defaults. A stalled result stays on out_* and the back end waits; once
//   the queue is full the front raises in_stall.
//
module combo_weight_solver_unit import cws_pkg::*; #(
  parameter int MAX_PAIRS = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_slider_value,
  input  logic signed [15:0] in_target_value,
  input  logic               in_last_pair,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_signs_match,
  output logic [MAG_W-1:0]   out_weight,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [MAG_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int QW = $bits(cws_run_t) + CW;

  logic [2:0]       solve_mode_r;
  logic [MAG_W-1:0] max_value_r;
  logic [7:0]       zero_tolerance_r;

  logic          q_full, q_empty, q_push, q_pop;
  cws_run_t      push_run, pop_run;
  logic [CW-1:0] push_count, pop_count;
  logic [QW-1:0] q_wr, q_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solve_mode_r     <= SOLVE_MODE_RST;
      max_value_r      <= MAX_VALUE_RST;
      zero_tolerance_r <= ZERO_TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SOLVE_MODE:     solve_mode_r     <= cfg_data[2:0];
        CFG_MAX_VALUE:      max_value_r      <= cfg_data;
        CFG_ZERO_TOLERANCE: zero_tolerance_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  cws_front #(
    .MAX_PAIRS(MAX_PAIRS),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_slider_value(in_slider_value),
    .in_target_value(in_target_value),
    .in_last_pair   (in_last_pair),
    .max_value      (max_value_r),
    .zero_tolerance (zero_tolerance_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_run          (push_run),
    .q_count        (push_count)
  );

  assign q_wr = {push_count, push_run};

  cws_queue #(
    .W(QW)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr),
    .pop    (q_pop),
    .rd_data(q_rd),
    .full   (q_full),
    .empty  (q_empty)
  );

  assign pop_run   = q_rd[$bits(cws_run_t)-1:0];
  assign pop_count = q_rd[QW-1:$bits(cws_run_t)];

  cws_back #(
    .MAX_PAIRS(MAX_PAIRS),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .solve_mode     (solve_mode_r),
    .zero_tolerance (zero_tolerance_r),
    .q_empty        (q_empty),
    .q_run          (pop_run),
    .q_count        (pop_count),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_signs_match(out_signs_match),
    .out_weight     (out_weight)
  );

endmodule

### design/cws_front.sv
// Front end: takes (value, target) pairs, does the sign test and folds
// clamped magnitudes into the run state. Depends on cws_pkg.
`timescale 1ns / 1ps

module cws_front import cws_pkg::*; #(
  parameter int MAX_PAIRS = 16,
  parameter int FRAC_BITS = 14,
  localparam int CW = $clog2(MAX_PAIRS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [15:0] in_slider_value,
  input  logic signed [15:0] in_target_value,
  input  logic              in_last_pair,
  input  logic [MAG_W-1:0]  max_value,
  input  logic [7:0]        zero_tolerance,
  input  logic              q_full,
  output logic              q_push,
  output cws_run_t          q_run,
  output logic [CW-1:0]     q_count
);

  localparam logic [30:0] HALF_Q = 31'(64'd1 << (FRAC_BITS - 1));
  localparam logic [MAG_W-1:0] PROD_INIT = MAG_W'((64'd1 << FRAC_BITS) & 64'h7FFF);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAIRS);

  logic             mism_r, mism_nxt;
  logic [MAG_W-1:0] min_r, min_nxt;
  logic [MAG_W-1:0] max_r, max_nxt;
  logic [MAG_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  logic             accept;
  logic signed [16:0] eps_s;
  logic             val_pos, tar_pos;
  logic [15:0]      val_abs;
  logic [MAG_W-1:0] mag;
  logic [29:0]      prod_mul;
  logic [30:0]      prod_rnd;
  logic [30:0]      prod_sh;
  logic [SUM_W:0]   sum_add;
  cws_run_t         upd;
  logic [CW-1:0]    upd_cnt;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_comb begin
    eps_s   = $signed({9'b0, zero_tolerance});
    val_pos = $signed({in_slider_value[15], in_slider_value}) > eps_s;
    tar_pos = $signed({in_target_value[15], in_target_value}) > eps_s;
    // -(-32768) wraps to 0x8000, which is the right unsigned magnitude
    val_abs = in_slider_value[15] ? 16'(-in_slider_value) : in_slider_value;
    mag     = (val_abs > {1'b0, max_value}) ? max_value : val_abs[MAG_W-1:0];

    prod_mul = prod_r * mag;
    prod_rnd = {1'b0, prod_mul} + HALF_Q;
    prod_sh  = prod_rnd >> FRAC_BITS;
    sum_add  = {1'b0, sum_r} + {{(SUM_W+1-MAG_W){1'b0}}, mag};

    upd.mismatch    = mism_r | (val_pos != tar_pos);
    upd.run_min     = (mag < min_r) ? mag : min_r;
    upd.run_max     = (mag > max_r) ? mag : max_r;
    upd.run_product = (prod_sh > 31'(MAG_MAX)) ? MAG_MAX : prod_sh[MAG_W-1:0];
    upd.run_sum     = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    upd_cnt         = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

    mism_nxt = mism_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    prod_nxt = prod_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (in_last_pair) begin
        mism_nxt = 1'b0;
        min_nxt  = MAG_MAX;
        max_nxt  = '0;
        prod_nxt = PROD_INIT;
        sum_nxt  = '0;
        cnt_nxt  = '0;
      end else begin
        mism_nxt = upd.mismatch;
        min_nxt  = upd.run_min;
        max_nxt  = upd.run_max;
        prod_nxt = upd.run_product;
        sum_nxt  = upd.run_sum;
        cnt_nxt  = upd_cnt;
      end
    end
  end

  assign q_push  = accept & in_last_pair;
  assign q_run   = upd;
  assign q_count = upd_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mism_r <= 1'b0;
      min_r  <= MAG_MAX;
      max_r  <= '0;
      prod_r <= PROD_INIT;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      mism_r <= mism_nxt;
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### design/cws_queue.sv
// Two-entry queue of finished run summaries between front and back.
// Imports cws_pkg, though it uses none of its types or constants.
`timescale 1ns / 1ps

module cws_queue import cws_pkg::*; #(
  parameter int W = 66
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### design/cws_back.sv
// Back end: takes one run summary, solves the weight for the selected mode
// (multiply, then in the harmonic modes a restoring divider at one quotient
// bit per cycle), and holds the result until it is transferred. Depends on cws_pkg.
`timescale 1ns / 1ps

module cws_back import cws_pkg::*; #(
  parameter int MAX_PAIRS = 16,
  parameter int FRAC_BITS = 14,
  localparam int CW = $clog2(MAX_PAIRS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [2:0]       solve_mode,
  input  logic [7:0]       zero_tolerance,
  input  logic             q_empty,
  input  cws_run_t         q_run,
  input  logic [CW-1:0]    q_count,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_signs_match,
  output logic [MAG_W-1:0] out_weight
);

  localparam int MW   = (CW + MAG_W > 30) ? CW + MAG_W : 30;
  localparam int N4W  = CW + MAG_W + FRAC_BITS + 1;
  localparam int NUMW = (N4W > 36) ? N4W : 36;
  localparam logic [30:0] HALF_Q = 31'(64'd1 << (FRAC_BITS - 1));

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  cws_run_t         job_r, job_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [MW-1:0]    mul_r, mul_nxt;
  logic [NUMW-1:0]  rem_r, rem_nxt;
  logic [NUMW-1:0]  dsh_r, dsh_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic             match_r, match_nxt;
  logic [MAG_W-1:0] weight_r, weight_nxt;

  logic [15:0]      den3;
  logic [SUM_W-1:0] den;
  logic [NUMW-1:0]  num;
  logic [NUMW-1:0]  den_sat;
  logic [30:0]      r2_rnd;
  logic [30:0]      r2_sh;
  logic             ge;

  assign out_valid       = (state_r == ST_OUT);
  assign out_signs_match = match_r;
  assign out_weight      = weight_r;
  assign q_pop           = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    den3    = {1'b0, job_r.run_max} + {1'b0, job_r.run_min};
    den     = (solve_mode == MODE_EXT_HARM) ? SUM_W'(den3) : job_r.run_sum;
    if (solve_mode == MODE_EXT_HARM) begin
      num = NUMW'({mul_r[29:0], 1'b0}) + NUMW'(den3 >> 1);
    end else begin
      num = (NUMW'(mul_r) << FRAC_BITS) + NUMW'(job_r.run_sum >> 1);
    end
    den_sat = NUMW'(den) << QUO_W;
    r2_rnd  = {1'b0, mul_r[29:0]} + HALF_Q;
    r2_sh   = r2_rnd >> FRAC_BITS;
    ge      = (rem_r >= dsh_r);
  end

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    cnt_nxt    = cnt_r;
    mul_nxt    = mul_r;
    rem_nxt    = rem_r;
    dsh_nxt    = dsh_r;
    quo_nxt    = quo_r;
    bit_nxt    = bit_r;
    match_nxt  = match_r;
    weight_nxt = weight_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          job_nxt   = q_run;
          cnt_nxt   = q_count;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (solve_mode == MODE_ALL_HARM) begin
          mul_nxt = MW'(cnt_r) * MW'(job_r.run_product);
        end else begin
          mul_nxt = MW'(job_r.run_max) * MW'(job_r.run_min);
        end
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        match_nxt = ~job_r.mismatch;
        state_nxt = ST_OUT;
        if (job_r.mismatch) begin
          weight_nxt = '0;
        end else begin
          case (solve_mode)
            MODE_PRODUCT: weight_nxt = job_r.run_product;
            MODE_MIN_MAX: begin
              weight_nxt = (r2_sh > 31'(MAG_MAX)) ? MAG_MAX : r2_sh[MAG_W-1:0];
            end
            MODE_EXT_HARM, MODE_ALL_HARM: begin
              // near-zero denominator gives zero; quotients past 15 bits saturate
              if (den <= SUM_W'(zero_tolerance)) begin
                weight_nxt = '0;
              end else if (num >= den_sat) begin
                weight_nxt = MAG_MAX;
              end else begin
                rem_nxt   = num;
                dsh_nxt   = NUMW'(den) << (QUO_W - 1);
                quo_nxt   = '0;
                bit_nxt   = 4'(QUO_W - 1);
                state_nxt = ST_DIV;
              end
            end
            default: weight_nxt = job_r.run_min;
          endcase
        end
      end
      ST_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - dsh_r;
        end
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        dsh_nxt = dsh_r >> 1;
        bit_nxt = bit_r - 4'd1;
        if (bit_r == 4'd0) begin
          weight_nxt = quo_nxt;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    cnt_r    <= cnt_nxt;
    mul_r    <= mul_nxt;
    rem_r    <= rem_nxt;
    dsh_r    <= dsh_nxt;
    quo_r    <= quo_nxt;
    bit_r    <= bit_nxt;
    match_r  <= match_nxt;
    weight_r <= weight_nxt;
  end

endmodule

### design/cws_checker.sv
// Port-level checks on the result channel of combo_weight_solver_unit,
// attached by the bind at the bottom. Depends on cws_pkg.
`timescale 1ns / 1ps

module cws_checker import cws_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_signs_match,
  input logic [MAG_W-1:0] out_weight
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_weight)
      && $stable(out_signs_match))
    else $error("result changed while stalled");

  // failed runs always report zero weight
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_signs_match |-> out_weight == '0)
    else $error("nonzero weight on sign mismatch");

  // nothing is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // each run is solved from scratch, so results never come back to back
  a_one_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated or back to back");

endmodule

bind combo_weight_solver_unit cws_checker u_cws_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_signs_match(out_signs_match),
  .out_weight     (out_weight)
);
